### rtl/wes_pkg.sv
`default_nettype none
package wes_pkg;

  localparam int DefMaxRows   = 128;
  localparam int DefMaxCols   = 128;
  localparam int DefHeightBits = 16;

  localparam logic [1:0] MODE_DISTURB = 2'd0;
  localparam logic [1:0] MODE_STEP    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  // The spare code is handled as a read.
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [2:0] REG_ROWS           = 3'd0;
  localparam logic [2:0] REG_COLS           = 3'd1;
  localparam logic [2:0] REG_COEFF_PREV     = 3'd2;
  localparam logic [2:0] REG_COEFF_CENTER   = 3'd3;
  localparam logic [2:0] REG_COEFF_NEIGHBOR = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] magnitude;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               rejected;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIST_RD,
    ST_DIST_WR,
    ST_STEP,
    ST_FETCH,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

### rtl/wave_equation_grid_stencil.sv
// Finite-difference wave grid held in two height banks of MAX_ROWS*MAX_COLS entries, each a
// synchronous memory with one read and one write port. After reset a clearing pass writes zero
// to every entry of both banks, during which no command is taken (register writes are). One
// command is worked on at a time. Each of a disturb's five cells is a read then a write. In a
// step, each interior cell needs five reads of the current bank through its single port, then
// three products through one shared multiplier, then the write into the other bank. The
// response beat sits in an output register, so it may wait for the consumer while the next
// command is already accepted.
`default_nettype none
module wave_equation_grid_stencil #(
  parameter int MAX_ROWS    = wes_pkg::DefMaxRows,
  parameter int MAX_COLS    = wes_pkg::DefMaxCols,
  parameter int HEIGHT_BITS = wes_pkg::DefHeightBits
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire wes_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output wes_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int HB    = HEIGHT_BITS;
  localparam int NW    = HB + 2;
  localparam int PW    = 18 + NW;
  localparam int AC    = PW + 2;
  localparam int OW    = (HB > 16) ? HB : 16;
  localparam logic [AW-1:0] STRIDE   = AW'(MAX_COLS);
  localparam logic [AW-1:0] LAST_ADR = AW'(CELLS - 1);
  localparam logic signed [AC-1:0] HMAX  = AC'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [AC-1:0] HMIN  = -HMAX - AC'(1);
  localparam logic signed [AC-1:0] ROUND = AC'(64'sd8192);

  function automatic logic [HB-1:0] sat_h(input logic signed [AC-1:0] v);
    logic [HB-1:0] r;
    if (v > HMAX) r = HMAX[HB-1:0];
    else if (v < HMIN) r = HMIN[HB-1:0];
    else r = v[HB-1:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [10:0] r, input logic [10:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(MAX_COLS) + 32'(c);
    return a[AW-1:0];
  endfunction

  // Configuration registers.
  logic [7:0]         rows_cfg, cols_cfg;
  logic signed [17:0] coeff_prev, coeff_center, coeff_neighbor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg       <= 8'd128;
      cols_cfg       <= 8'd128;
      coeff_prev     <= '0;
      coeff_center   <= '0;
      coeff_neighbor <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        wes_pkg::REG_ROWS:           rows_cfg       <= pwdata[7:0];
        wes_pkg::REG_COLS:           cols_cfg       <= pwdata[7:0];
        wes_pkg::REG_COEFF_PREV:     coeff_prev     <= pwdata[17:0];
        wes_pkg::REG_COEFF_CENTER:   coeff_center   <= pwdata[17:0];
        wes_pkg::REG_COEFF_NEIGHBOR: coeff_neighbor <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      wes_pkg::REG_ROWS:           prdata = {24'd0, rows_cfg};
      wes_pkg::REG_COLS:           prdata = {24'd0, cols_cfg};
      wes_pkg::REG_COEFF_PREV:     prdata = 32'(coeff_prev);
      wes_pkg::REG_COEFF_CENTER:   prdata = 32'(coeff_center);
      wes_pkg::REG_COEFF_NEIGHBOR: prdata = 32'(coeff_neighbor);
      default:                     prdata = '0;
    endcase
  end

  // Grid size clamped to the supported range.
  logic [10:0] rows_eff, cols_eff;
  always_comb begin
    if (rows_cfg < 8'd4) rows_eff = 11'd4;
    else if (11'(rows_cfg) > 11'(MAX_ROWS)) rows_eff = 11'(MAX_ROWS);
    else rows_eff = 11'(rows_cfg);
    if (cols_cfg < 8'd4) cols_eff = 11'd4;
    else if (11'(cols_cfg) > 11'(MAX_COLS)) cols_eff = 11'(MAX_COLS);
    else cols_eff = 11'(cols_cfg);
  end

  // Height banks.
  logic [HB-1:0] bank0 [CELLS];
  logic [HB-1:0] bank1 [CELLS];
  logic          b0_re, b0_we, b1_re, b1_we;
  logic [AW-1:0] b0_raddr, b0_waddr, b1_raddr, b1_waddr;
  logic [HB-1:0] b0_wdata, b1_wdata, b0_rdata, b1_rdata;

  always_ff @(posedge clk) begin
    if (b0_we) bank0[b0_waddr] <= b0_wdata;
    if (b0_re) b0_rdata <= bank0[b0_raddr];
  end

  always_ff @(posedge clk) begin
    if (b1_we) bank1[b1_waddr] <= b1_wdata;
    if (b1_re) b1_rdata <= bank1[b1_raddr];
  end

  // Control and datapath registers.
  wes_pkg::state_t    state, state_next;
  logic               cur_bank;
  logic [AW-1:0]      clr_addr;
  wes_pkg::cmd_t      item;
  logic               rej;
  logic [2:0]         nb;
  logic [RW-1:0]      si;
  logic [CW-1:0]      sj;
  logic [3:0]         ph;
  logic signed [HB-1:0] cval, pval;
  logic signed [NW-1:0] nsum;
  logic signed [PW-1:0] prod;
  logic signed [AC-1:0] acc;

  // Logical view of the banks: current and previous.
  logic          cur_re, cur_we, prv_re, prv_we;
  logic [AW-1:0] cur_raddr, cur_waddr, prv_raddr, prv_waddr;
  logic [HB-1:0] cur_wdata, prv_wdata;
  logic signed [HB-1:0] cur_rdata, prv_rdata;

  assign cur_rdata = cur_bank ? b1_rdata : b0_rdata;
  assign prv_rdata = cur_bank ? b0_rdata : b1_rdata;
  assign b0_re    = cur_bank ? prv_re    : cur_re;
  assign b0_raddr = cur_bank ? prv_raddr : cur_raddr;
  assign b0_we    = cur_bank ? prv_we    : cur_we;
  assign b0_waddr = cur_bank ? prv_waddr : cur_waddr;
  assign b0_wdata = cur_bank ? prv_wdata : cur_wdata;
  assign b1_re    = cur_bank ? cur_re    : prv_re;
  assign b1_raddr = cur_bank ? cur_raddr : prv_raddr;
  assign b1_we    = cur_bank ? cur_we    : prv_we;
  assign b1_waddr = cur_bank ? cur_waddr : prv_waddr;
  assign b1_wdata = cur_bank ? cur_wdata : prv_wdata;

  logic                 in_grid, dist_ok, last_col, last_row, rsp_load;
  logic [AW-1:0]        item_addr, cell_addr, dist_addr;
  logic signed [15:0]   dist_val;
  logic signed [AC-1:0] dist_sum, acc_round;
  logic signed [17:0]   mul_a;
  logic signed [NW-1:0] mul_b;
  logic signed [PW-1:0] mul_out;
  logic signed [OW-1:0] height_ext;

  assign in_grid = (11'(item.row) < rows_eff) && (11'(item.col) < cols_eff);
  assign dist_ok = (cmd.row >= 7'd2) && (11'(cmd.row) + 11'd3 <= rows_eff)
                && (cmd.col >= 7'd2) && (11'(cmd.col) + 11'd3 <= cols_eff);
  assign item_addr = addr_of(11'(item.row), 11'(item.col));
  assign cell_addr = addr_of(11'(si), 11'(sj));
  assign last_col  = (11'(sj) == cols_eff - 11'd2);
  assign last_row  = (11'(si) == rows_eff - 11'd2);

  always_comb begin
    case (nb)
      3'd1:    dist_addr = item_addr + AW'(1);
      3'd2:    dist_addr = item_addr - AW'(1);
      3'd3:    dist_addr = item_addr + STRIDE;
      3'd4:    dist_addr = item_addr - STRIDE;
      default: dist_addr = item_addr;
    endcase
  end

  assign dist_val  = (nb == 3'd0) ? item.magnitude : (item.magnitude >>> 1);
  assign dist_sum  = AC'(cur_rdata) + AC'(dist_val);
  assign acc_round = (acc + ROUND) >>> 14;

  // One multiplier shared by the three stencil terms.
  always_comb begin
    case (ph)
      4'd5:    begin mul_a = coeff_prev;     mul_b = NW'(pval); end
      4'd6:    begin mul_a = coeff_center;   mul_b = NW'(cval); end
      default: begin mul_a = coeff_neighbor; mul_b = nsum;      end
    endcase
  end
  assign mul_out = mul_a * mul_b;

  assign height_ext = OW'(cur_rdata);
  assign rsp_load   = (state == wes_pkg::ST_RESULT) && (!rsp_valid || rsp_ready);
  assign cmd_ready  = (state == wes_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cur_re = 1'b0; cur_raddr = cell_addr;
    cur_we = 1'b0; cur_waddr = dist_addr; cur_wdata = sat_h(dist_sum);
    prv_re = 1'b0; prv_raddr = cell_addr;
    prv_we = 1'b0; prv_waddr = cell_addr; prv_wdata = sat_h(acc_round);
    case (state)
      wes_pkg::ST_CLEAR: begin
        cur_we = 1'b1; cur_waddr = clr_addr; cur_wdata = '0;
        prv_we = 1'b1; prv_waddr = clr_addr; prv_wdata = '0;
        if (clr_addr == LAST_ADR) state_next = wes_pkg::ST_IDLE;
      end
      wes_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.mode == wes_pkg::MODE_DISTURB && dist_ok) state_next = wes_pkg::ST_DIST_RD;
          else if (cmd.mode == wes_pkg::MODE_STEP) state_next = wes_pkg::ST_STEP;
          else state_next = wes_pkg::ST_FETCH;
        end
      end
      wes_pkg::ST_DIST_RD: begin
        cur_re = 1'b1; cur_raddr = dist_addr;
        state_next = wes_pkg::ST_DIST_WR;
      end
      wes_pkg::ST_DIST_WR: begin
        cur_we = 1'b1;
        state_next = (nb == 3'd4) ? wes_pkg::ST_FETCH : wes_pkg::ST_DIST_RD;
      end
      wes_pkg::ST_STEP: begin
        case (ph)
          4'd0: begin cur_re = 1'b1; prv_re = 1'b1; end
          4'd1: begin cur_re = 1'b1; cur_raddr = cell_addr - STRIDE; end
          4'd2: begin cur_re = 1'b1; cur_raddr = cell_addr + STRIDE; end
          4'd3: begin cur_re = 1'b1; cur_raddr = cell_addr - AW'(1); end
          4'd4: begin cur_re = 1'b1; cur_raddr = cell_addr + AW'(1); end
          4'd9: begin
            prv_we = 1'b1;
            if (last_col && last_row) state_next = wes_pkg::ST_FETCH;
          end
          default: ;
        endcase
      end
      wes_pkg::ST_FETCH: begin
        cur_re = in_grid; cur_raddr = item_addr;
        state_next = wes_pkg::ST_RESULT;
      end
      wes_pkg::ST_RESULT: begin
        if (rsp_load) state_next = wes_pkg::ST_IDLE;
      end
      default: state_next = wes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wes_pkg::ST_CLEAR;
      cur_bank  <= 1'b0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wes_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == wes_pkg::ST_STEP && ph == 4'd9 && last_col && last_row) begin
        cur_bank <= ~cur_bank;
      end
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wes_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          item <= cmd;
          rej  <= (cmd.mode == wes_pkg::MODE_DISTURB) && !dist_ok;
          nb   <= 3'd0;
          si   <= RW'(1);
          sj   <= CW'(1);
          ph   <= 4'd0;
        end
      end
      wes_pkg::ST_DIST_WR: nb <= nb + 3'd1;
      wes_pkg::ST_STEP: begin
        case (ph)
          4'd1: begin cval <= cur_rdata; pval <= prv_rdata; end
          4'd2: nsum <= NW'(cur_rdata);
          4'd3, 4'd4, 4'd5: nsum <= nsum + NW'(cur_rdata);
          default: ;
        endcase
        if (ph == 4'd5 || ph == 4'd6 || ph == 4'd7) prod <= mul_out;
        if (ph == 4'd6) acc <= AC'(prod);
        if (ph == 4'd7 || ph == 4'd8) acc <= acc + AC'(prod);
        if (ph == 4'd9) begin
          ph <= 4'd0;
          if (last_col) begin
            sj <= CW'(1);
            si <= si + RW'(1);
          end else begin
            sj <= sj + CW'(1);
          end
        end else begin
          ph <= ph + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.height   <= in_grid ? height_ext[15:0] : 16'sd0;
      rsp.rejected <= rej;
    end
  end

endmodule
`default_nettype wire
